// File: rtl/jtv_pkg.sv
// ----------------------------------------------------------------------------
// JSON text validator package
// Shared word types, parse modes and sizing constants.
// ----------------------------------------------------------------------------
package jtv_pkg;

   localparam int MAX_NEST   = 32;
   localparam int STACK_DEPTH = MAX_NEST + 1;
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int NEST_W      = $clog2(MAX_NEST + 2);

   typedef enum logic [4:0] {
      M_VALUE     = 5'd0,
      M_ARR_FIRST = 5'd1,
      M_OBJ_FIRST = 5'd2,
      M_KEY       = 5'd3,
      M_COLON     = 5'd4,
      M_AFTER     = 5'd5,
      M_STR       = 5'd6,
      M_ESC       = 5'd7,
      M_HEX       = 5'd8,
      M_UTF       = 5'd9,
      M_KSTR      = 5'd10,
      M_KESC      = 5'd11,
      M_KHEX      = 5'd12,
      M_KUTF      = 5'd13,
      M_LIT       = 5'd14,
      M_N_MINUS   = 5'd15,
      M_N_ZERO    = 5'd16,
      M_N_INT     = 5'd17,
      M_N_DOT     = 5'd18,
      M_N_FRAC    = 5'd19,
      M_N_E       = 5'd20,
      M_N_ESIGN   = 5'd21,
      M_N_EXP     = 5'd22
   } mode_type;

   typedef enum logic [1:0] {
      RULE_NONE  = 2'd0,
      RULE_FLOOR = 2'd1,
      RULE_CEIL  = 2'd2
   } rule_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic error_flag;
      logic text_done;
   } rsp_word_type;

   // Letter expected at each literal position of "truefalsenull".
   function automatic logic [7:0] lit_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:  c = "t";
         4'd1:  c = "r";
         4'd2:  c = "u";
         4'd3:  c = "e";
         4'd4:  c = "f";
         4'd5:  c = "a";
         4'd6:  c = "l";
         4'd7:  c = "s";
         4'd8:  c = "e";
         4'd9:  c = "n";
         4'd10: c = "u";
         4'd11: c = "l";
         4'd12: c = "l";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/jtv_step.sv
// ----------------------------------------------------------------------------
// JSON validator step logic
// Computes the next parser state for one text byte.
// ----------------------------------------------------------------------------
module jtv_step (
   input  logic [7:0]                     b,
   input  jtv_pkg::mode_type              mode,
   input  logic [jtv_pkg::NEST_W-1:0]     nest,
   input  logic                           top_is_obj,
   input  logic [1:0]                     utf_left,
   input  jtv_pkg::rule_type              rule,
   input  logic [2:0]                     hex_left,
   input  logic [4:0]                     lit,
   output jtv_pkg::mode_type              mode_n,
   output logic [jtv_pkg::NEST_W-1:0]     nest_n,
   output logic                           push,
   output logic                           push_obj,
   output logic [1:0]                     utf_left_n,
   output jtv_pkg::rule_type              rule_n,
   output logic [2:0]                     hex_left_n,
   output logic [4:0]                     lit_n,
   output logic                           fail
);
   logic ws, dig, hex, kstr;
   logic [7:0] thr;
   jtv_pkg::mode_type sub;

   assign ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
   assign dig = (b >= "0") && (b <= "9");
   assign hex = dig || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
   assign kstr = (mode == jtv_pkg::M_KSTR) || (mode == jtv_pkg::M_KESC) ||
                 (mode == jtv_pkg::M_KHEX) || (mode == jtv_pkg::M_KUTF);
   assign thr = (utf_left == 2'd3) ? 8'h90 : 8'ha0;

   always_comb begin
      mode_n     = mode;
      nest_n     = nest;
      push       = 1'b0;
      push_obj   = 1'b0;
      utf_left_n = utf_left;
      rule_n     = rule;
      hex_left_n = hex_left;
      lit_n      = lit;
      fail       = 1'b0;
      sub        = kstr ? jtv_pkg::mode_type'(mode - 5'd4) : mode;

      case (mode)
         jtv_pkg::M_VALUE, jtv_pkg::M_ARR_FIRST: begin
            if (ws) begin
            end else if (mode == jtv_pkg::M_ARR_FIRST && b == "]") begin
               nest_n = nest - 1'b1;
               mode_n = jtv_pkg::M_AFTER;
            end else if (nest > jtv_pkg::NEST_W'(jtv_pkg::MAX_NEST)) begin
               fail = 1'b1;
            end else if (b == "\"") begin
               mode_n = jtv_pkg::M_STR;
            end else if (b == "{") begin
               push = 1'b1; push_obj = 1'b1;
               nest_n = nest + 1'b1;
               mode_n = jtv_pkg::M_OBJ_FIRST;
            end else if (b == "[") begin
               push = 1'b1;
               nest_n = nest + 1'b1;
               mode_n = jtv_pkg::M_ARR_FIRST;
            end else if (b == "t") begin
               lit_n = 5'd1; mode_n = jtv_pkg::M_LIT;
            end else if (b == "f") begin
               lit_n = 5'd5; mode_n = jtv_pkg::M_LIT;
            end else if (b == "n") begin
               lit_n = 5'd10; mode_n = jtv_pkg::M_LIT;
            end else if (b == "-") begin
               mode_n = jtv_pkg::M_N_MINUS;
            end else if (b == "0") begin
               mode_n = jtv_pkg::M_N_ZERO;
            end else if (dig) begin
               mode_n = jtv_pkg::M_N_INT;
            end else begin
               fail = 1'b1;
            end
         end
         jtv_pkg::M_OBJ_FIRST, jtv_pkg::M_KEY: begin
            if (ws) begin
            end else if (b == "}" && mode == jtv_pkg::M_OBJ_FIRST) begin
               nest_n = nest - 1'b1;
               mode_n = jtv_pkg::M_AFTER;
            end else if (b == "\"") begin
               mode_n = jtv_pkg::M_KSTR;
            end else begin
               fail = 1'b1;
            end
         end
         jtv_pkg::M_COLON: begin
            if (ws) begin
            end else if (b == ":") begin
               mode_n = jtv_pkg::M_VALUE;
            end else begin
               fail = 1'b1;
            end
         end
         jtv_pkg::M_STR, jtv_pkg::M_ESC, jtv_pkg::M_HEX, jtv_pkg::M_UTF,
         jtv_pkg::M_KSTR, jtv_pkg::M_KESC, jtv_pkg::M_KHEX, jtv_pkg::M_KUTF: begin
            case (sub)
               jtv_pkg::M_STR: begin
                  if (b == "\"") begin
                     mode_n = kstr ? jtv_pkg::M_COLON : jtv_pkg::M_AFTER;
                  end else if (b < 8'h20) begin
                     fail = 1'b1;
                  end else if (b == "\\") begin
                     mode_n = kstr ? jtv_pkg::M_KESC : jtv_pkg::M_ESC;
                  end else if (b >= 8'h80) begin
                     rule_n = jtv_pkg::RULE_NONE;
                     if (b >= 8'hc2 && b <= 8'hdf) utf_left_n = 2'd1;
                     else if (b >= 8'he0 && b <= 8'hef) utf_left_n = 2'd2;
                     else if (b >= 8'hf0 && b <= 8'hf4) utf_left_n = 2'd3;
                     else fail = 1'b1;
                     if (b == 8'he0 || b == 8'hf0) rule_n = jtv_pkg::RULE_FLOOR;
                     if (b == 8'hed || b == 8'hf4) rule_n = jtv_pkg::RULE_CEIL;
                     mode_n = kstr ? jtv_pkg::M_KUTF : jtv_pkg::M_UTF;
                  end
               end
               jtv_pkg::M_ESC: begin
                  if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                      b == "n" || b == "r" || b == "t") begin
                     mode_n = kstr ? jtv_pkg::M_KSTR : jtv_pkg::M_STR;
                  end else if (b == "u") begin
                     hex_left_n = 3'd4;
                     mode_n = kstr ? jtv_pkg::M_KHEX : jtv_pkg::M_HEX;
                  end else begin
                     fail = 1'b1;
                  end
               end
               jtv_pkg::M_HEX: begin
                  if (!hex || hex_left == 3'd0) begin
                     fail = 1'b1;
                  end else begin
                     hex_left_n = hex_left - 3'd1;
                     if (hex_left == 3'd1)
                        mode_n = kstr ? jtv_pkg::M_KSTR : jtv_pkg::M_STR;
                  end
               end
               default: begin
                  if (b[7:6] != 2'b10 || utf_left == 2'd0) begin
                     fail = 1'b1;
                  end else if ((rule == jtv_pkg::RULE_FLOOR && b < thr) ||
                               (rule == jtv_pkg::RULE_CEIL && b >= thr)) begin
                     fail = 1'b1;
                  end else begin
                     rule_n = jtv_pkg::RULE_NONE;
                     utf_left_n = utf_left - 2'd1;
                     if (utf_left == 2'd1)
                        mode_n = kstr ? jtv_pkg::M_KSTR : jtv_pkg::M_STR;
                  end
               end
            endcase
         end
         jtv_pkg::M_LIT: begin
            if (lit >= 5'd13 || jtv_pkg::lit_char(lit[3:0]) != b) begin
               fail = 1'b1;
            end else if (lit == 5'd3 || lit == 5'd8 || lit == 5'd12) begin
               lit_n = 5'd0;
               mode_n = jtv_pkg::M_AFTER;
            end else begin
               lit_n = lit + 5'd1;
            end
         end
         jtv_pkg::M_N_MINUS: begin
            if (b == "0") mode_n = jtv_pkg::M_N_ZERO;
            else if (dig) mode_n = jtv_pkg::M_N_INT;
            else fail = 1'b1;
         end
         jtv_pkg::M_N_DOT: begin
            if (dig) mode_n = jtv_pkg::M_N_FRAC; else fail = 1'b1;
         end
         jtv_pkg::M_N_E: begin
            if (b == "+" || b == "-") mode_n = jtv_pkg::M_N_ESIGN;
            else if (dig) mode_n = jtv_pkg::M_N_EXP;
            else fail = 1'b1;
         end
         jtv_pkg::M_N_ESIGN: begin
            if (dig) mode_n = jtv_pkg::M_N_EXP; else fail = 1'b1;
         end
         jtv_pkg::M_AFTER, jtv_pkg::M_N_ZERO, jtv_pkg::M_N_INT,
         jtv_pkg::M_N_FRAC, jtv_pkg::M_N_EXP: begin
            if (mode == jtv_pkg::M_N_ZERO && dig) begin
               fail = 1'b1;
            end else if (mode != jtv_pkg::M_AFTER && mode != jtv_pkg::M_N_ZERO && dig) begin
            end else if (b == "." && (mode == jtv_pkg::M_N_ZERO ||
                                      mode == jtv_pkg::M_N_INT)) begin
               mode_n = jtv_pkg::M_N_DOT;
            end else if ((b == "e" || b == "E") && mode != jtv_pkg::M_N_EXP &&
                         mode != jtv_pkg::M_AFTER) begin
               mode_n = jtv_pkg::M_N_E;
            end else begin
               // Anything else closes the value.
               mode_n = jtv_pkg::M_AFTER;
               if (ws) begin
               end else if (nest == '0 ||
                            nest > jtv_pkg::NEST_W'(jtv_pkg::MAX_NEST + 1)) begin
                  fail = 1'b1;
               end else if (b == ",") begin
                  mode_n = top_is_obj ? jtv_pkg::M_KEY : jtv_pkg::M_VALUE;
               end else if ((b == "]" && !top_is_obj) || (b == "}" && top_is_obj)) begin
                  nest_n = nest - 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end
         end
         default: fail = 1'b1;
      endcase
   end
endmodule

// File: rtl/json_text_validator.sv
// ----------------------------------------------------------------------------
// JSON text validator
// Streaming syntax check of JSON text, one byte per word.
// ----------------------------------------------------------------------------
// Each accepted byte word gives one result word in the next cycle, and a new
// word is taken every cycle while the output register is free or being
// drained; throughput is one byte per clock, with the state updated for each
// accepted byte. The top entry of the container stack is held in a register
// that is loaded only when a word is accepted, so the stack array is only
// read in the clocked block. A word with end_of_text set, or a zero byte,
// returns the verdict with text_done and returns the parser to its reset state.
module json_text_validator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  jtv_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output jtv_pkg::rsp_word_type rsp_word
);
   jtv_pkg::mode_type          mode_ff, mode_in, mode_s;
   logic [jtv_pkg::NEST_W-1:0] nest_ff, nest_in, nest_s;
   logic [1:0]                 utf_ff, utf_in, utf_s;
   jtv_pkg::rule_type          rule_ff, rule_in, rule_s;
   logic [2:0]                 hex_ff, hex_in, hex_s;
   logic [4:0]                 lit_ff, lit_in, lit_s;
   logic                       err_ff, err_in;
   logic                       stack_ff [jtv_pkg::STACK_DEPTH];
   logic                       top_ff, push, push_obj, fail;
   logic                       rsp_valid_ff;
   jtv_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;
   logic                       take, ending, ok;
   logic                       stack_we;
   logic [jtv_pkg::STACK_IDX_W-1:0] pop_idx;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;
   assign ending    = req_word.end_of_text || (req_word.data_byte == 8'h00);

   jtv_step u_step (
      .b(req_word.data_byte), .mode(mode_ff), .nest(nest_ff), .top_is_obj(top_ff),
      .utf_left(utf_ff), .rule(rule_ff), .hex_left(hex_ff), .lit(lit_ff),
      .mode_n(mode_s), .nest_n(nest_s), .push(push), .push_obj(push_obj),
      .utf_left_n(utf_s), .rule_n(rule_s), .hex_left_n(hex_s), .lit_n(lit_s),
      .fail(fail)
   );

   assign ok = !err_ff && nest_ff == '0 &&
               (mode_ff == jtv_pkg::M_AFTER || mode_ff == jtv_pkg::M_N_ZERO ||
                mode_ff == jtv_pkg::M_N_INT || mode_ff == jtv_pkg::M_N_FRAC ||
                mode_ff == jtv_pkg::M_N_EXP);

   always_comb begin
      mode_in = mode_ff; nest_in = nest_ff; utf_in = utf_ff; rule_in = rule_ff;
      hex_in = hex_ff; lit_in = lit_ff; err_in = err_ff;
      rsp_word_in.error_flag = err_ff;
      rsp_word_in.text_done  = 1'b0;
      if (ending) begin
         mode_in = jtv_pkg::M_VALUE; nest_in = '0; utf_in = 2'd0;
         rule_in = jtv_pkg::RULE_NONE; hex_in = 3'd0; lit_in = 5'd0; err_in = 1'b0;
         rsp_word_in.error_flag = !ok;
         rsp_word_in.text_done  = 1'b1;
      end else if (!err_ff) begin
         if (fail) begin
            err_in = 1'b1;
         end else begin
            mode_in = mode_s; nest_in = nest_s; utf_in = utf_s; rule_in = rule_s;
            hex_in = hex_s; lit_in = lit_s;
         end
         rsp_word_in.error_flag = fail;
      end
   end

   assign stack_we = take && !ending && !err_ff && !fail && push;
   assign pop_idx  = nest_in[jtv_pkg::STACK_IDX_W-1:0] - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jtv_pkg::M_VALUE; nest_ff <= '0; utf_ff <= 2'd0;
         rule_ff <= jtv_pkg::RULE_NONE; hex_ff <= 3'd0; lit_ff <= 5'd0;
         err_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            mode_ff <= mode_in; nest_ff <= nest_in; utf_ff <= utf_in;
            rule_ff <= rule_in; hex_ff <= hex_in; lit_ff <= lit_in; err_ff <= err_in;
         end
         if (take) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // A push writes the new top straight into top_ff; otherwise the entry
   // below the next depth is read, which is current since only pushes write.
   always_ff @(posedge clock) begin
      if (take) rsp_word_ff <= rsp_word_in;
      if (stack_we)
         stack_ff[nest_ff[jtv_pkg::STACK_IDX_W-1:0]] <= push_obj;
      if (take) begin
         if (stack_we) top_ff <= push_obj;
         else if (nest_in != '0) top_ff <= stack_ff[pop_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Nesting never exceeds the stack depth.
   a_nest_bound: assert property (@(posedge clock) disable iff (reset)
      nest_ff <= jtv_pkg::NEST_W'(jtv_pkg::STACK_DEPTH))
      else $error("nest level out of range");
   // An ending word leaves the parser in its start state.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && ending |=> mode_ff == jtv_pkg::M_VALUE && nest_ff == '0 && !err_ff)
      else $error("end of text did not clear state");
   // Error stays set until an ending word.
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !(take && ending) |=> err_ff)
      else $error("error flag dropped");
   // Continuation count is zero whenever the parser is outside a UTF-8 sequence.
   a_utf_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != jtv_pkg::M_UTF && mode_ff != jtv_pkg::M_KUTF) |-> utf_ff == 2'd0)
      else $error("utf8 count stale");
endmodule
